// ===== design/pps_pkg.sv =====
// shared types and constants for the perspective projection block
// no dependencies; compiled first
`timescale 1ns / 1ps
package pps_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int PT_W              = 32;
  localparam int Q_W               = 32;
  localparam int SIZE_W            = 14;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int MAT_REGS          = 6;
  localparam int LANES             = 2;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X_FIRST  = 3'd0,
    REG_ROW_X_SECOND = 3'd1,
    REG_ROW_Y_FIRST  = 3'd2,
    REG_ROW_Y_SECOND = 3'd3,
    REG_ROW_W_FIRST  = 3'd4,
    REG_ROW_W_SECOND = 3'd5,
    REG_SCREEN_WIDTH = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } cfg_reg_t;

  // sideband that rides along the divider
  typedef struct packed {
    logic             vis;
    logic [LANES-1:0] neg;
  } pps_tag_t;

  typedef struct packed {
    logic                   visible;
    logic signed [Q_W-1:0]  screen_x;
    logic signed [Q_W-1:0]  screen_y;
    logic                   overflowed;
  } pps_result_t;

endpackage

// ===== design/pps_cfg_if.sv =====
// configuration write channel
// depends on pps_pkg
`timescale 1ns / 1ps
interface pps_cfg_if;
  import pps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pps_point_if.sv =====
// input channel: one world point per item
// depends on pps_pkg
`timescale 1ns / 1ps
interface pps_point_if;
  import pps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;
  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// ===== design/pps_screen_if.sv =====
// output channel: one screen result per item
// depends on pps_pkg
`timescale 1ns / 1ps
interface pps_screen_if;
  import pps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  visible;
  logic signed [Q_W-1:0] screen_x;
  logic signed [Q_W-1:0] screen_y;
  logic                  overflowed;
  modport source (output valid, output visible, output screen_x, output screen_y,
                  output overflowed, input ready);
  modport sink   (input valid, input visible, input screen_x, input screen_y,
                  input overflowed, output ready);
endinterface

// ===== design/pps_div.sv =====
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage
// depends on pps_pkg
`timescale 1ns / 1ps
module pps_div #(
  parameter int DW = 50,
  parameter int NW = 81
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [pps_pkg::LANES-1:0][NW-1:0] num,
  input  logic [DW-1:0]                   den,
  input  pps_pkg::pps_tag_t               in_tag,
  output logic                            out_valid,
  output logic [pps_pkg::LANES-1:0][pps_pkg::Q_W-1:0] quo,
  output logic [pps_pkg::LANES-1:0]       rem_nz,
  output logic [pps_pkg::LANES-1:0]       ovf,
  output pps_pkg::pps_tag_t               out_tag
);
  import pps_pkg::*;

  localparam int QW = Q_W;
  localparam int HW = NW - QW;
  localparam int MW = (HW > DW) ? HW : DW;

  logic                         vld  [0:QW];
  logic [DW-1:0]                dreg [0:QW-1];
  pps_tag_t                     tag  [0:QW];
  logic [LANES-1:0][DW-1:0]     rem  [0:QW];
  logic [LANES-1:0][QW-1:0]     low  [0:QW];
  logic [LANES-1:0]             ovfs [0:QW];

  logic [LANES-1:0][MW-1:0]     hi_ext;
  logic [LANES-1:0]             ovf0;

  // quotient must fit in QW bits: high part of the dividend below the divisor
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      hi_ext[l] = MW'(num[l][NW-1:QW]);
      ovf0[l]   = hi_ext[l] >= MW'(den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dreg[0] <= den;
      tag[0]  <= in_tag;
      ovfs[0] <= ovf0;
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= DW'(hi_ext[l]);
        low[0][l] <= num[l][QW-1:0];
      end
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [LANES-1:0][DW:0]    t;
    logic [LANES-1:0][DW:0]    diff;
    logic [LANES-1:0]          ge;
    logic [LANES-1:0][DW-1:0]  rem_next;
    logic [LANES-1:0][QW-1:0]  low_next;

    // shift in the next dividend bit, subtract when it fits; low shifts out as q shifts in
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]        = {rem[s-1][l], low[s-1][l][QW-1]};
        diff[l]     = t[l] - {1'b0, dreg[s-1]};
        ge[l]       = t[l] >= {1'b0, dreg[s-1]};
        rem_next[l] = ge[l] ? diff[l][DW-1:0] : t[l][DW-1:0];
        low_next[l] = {low[s-1][l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tag[s]  <= tag[s-1];
        ovfs[s] <= ovfs[s-1];
        rem[s]  <= rem_next;
        low[s]  <= low_next;
      end
    end

    if (s < QW) begin : g_den
      always_ff @(posedge clk) begin
        if (adv) begin
          dreg[s] <= dreg[s-1];
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = low[QW];
  assign ovf       = ovfs[QW];
  assign out_tag   = tag[QW];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_nz[l] = |rem[QW][l];
    end
  end

endmodule

// ===== design/perspective_project_to_screen.sv =====
// perspective projection and viewport mapping, top level
// depends on pps_pkg, pps_cfg_if, pps_point_if, pps_screen_if and pps_div
//
//   channel  | dir | handshake   | payload
//   ---------+-----+-------------+------------------------------------------
//   cfg      | in  | valid/ready | index (3), data (64)
//   point    | in  | valid/ready | point_x, point_y, point_z (signed 32)
//   screen   | out | valid/ready | visible, screen_x, screen_y, overflowed
//
// one item per cycle sustained while the skid register is empty; an item reaches the output
// register through the divider (a load stage, then one quotient bit per stage)
// rst is synchronous; it clears valid bits and loads register defaults
// (identity-free zero matrix, 1920 x 1080 viewport)
// the whole pipe moves together; a skid register behind the output register
// catches one item when screen stalls, and point.ready drops only while it is full
// cfg is always ready; writes are expected only while the pipe is empty
`timescale 1ns / 1ps
module perspective_project_to_screen #(
  parameter int FRACTION_BITS = pps_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pps_cfg_if.sink      cfg,
  pps_point_if.sink    point,
  pps_screen_if.source screen
);
  import pps_pkg::*;

  localparam int PW     = 2 * PT_W;                 // one exact product
  localparam int SUM_W  = PW + 1;                   // three products
  localparam int CLIP_W = SUM_W - FRACTION_BITS + 1; // after shift, plus constant entry
  localparam int N_W    = CLIP_W + 1;               // w + x or w - y
  localparam int NUM_W  = N_W + SIZE_W + FRACTION_BITS;
  localparam int THRESH = ((1 << FRACTION_BITS) + 99) / 100;

  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_W = 2;

  // configuration registers
  logic [CFG_DATA_W-1:0] mat [MAT_REGS];
  logic [SIZE_W-1:0]     scr_w;
  logic [SIZE_W-1:0]     scr_h;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAT_REGS; i++) begin
        mat[i] <= '0;
      end
      scr_w <= WIDTH_RST;
      scr_h <= HEIGHT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_ROW_X_FIRST:   mat[0] <= cfg.data;
        REG_ROW_X_SECOND:  mat[1] <= cfg.data;
        REG_ROW_Y_FIRST:   mat[2] <= cfg.data;
        REG_ROW_Y_SECOND:  mat[3] <= cfg.data;
        REG_ROW_W_FIRST:   mat[4] <= cfg.data;
        REG_ROW_W_SECOND:  mat[5] <= cfg.data;
        REG_SCREEN_WIDTH:  scr_w  <= cfg.data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: scr_h  <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // matrix entries: rows x, y, w; column 3 is the constant term
  logic signed [PT_W-1:0] m [3][4];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      m[r][0] = mat[2*r][PT_W-1:0];
      m[r][1] = mat[2*r][CFG_DATA_W-1:PT_W];
      m[r][2] = mat[2*r+1][PT_W-1:0];
      m[r][3] = mat[2*r+1][CFG_DATA_W-1:PT_W];
    end
  end

  // pipe moves whenever the skid register is free
  logic adv;
  logic skid_vld;
  assign adv         = !skid_vld;
  assign point.ready = adv;

  logic signed [PT_W-1:0] pt [3];
  assign pt[0] = point.point_x;
  assign pt[1] = point.point_y;
  assign pt[2] = point.point_z;

  // stage 1: nine exact products
  logic                   v1;
  logic signed [PW-1:0]   prod1 [3][3];

  // stage 2: row sums of the products
  logic                   v2;
  logic signed [SUM_W-1:0] sum2 [3];

  // stage 3: clip coordinates, floored to the fixed-point grid
  logic                    v3;
  logic signed [CLIP_W-1:0] clip3 [3];

  // stage 4: numerators, divisor 2w, visibility
  logic                    v4;
  logic                    vis4;
  logic signed [N_W-1:0]   n4 [LANES];
  logic [CLIP_W-1:0]       d4;

  // stage 5: sign and magnitude
  logic                    v5;
  logic                    vis5;
  logic [LANES-1:0]        neg5;
  logic [N_W-1:0]          mag5 [LANES];
  logic [CLIP_W-1:0]       d5;

  // stage 6: scale by viewport size and the fraction
  logic                           v6;
  pps_tag_t                       tag6;
  logic [LANES-1:0][NUM_W-1:0]    num6;
  logic [CLIP_W-1:0]              d6;
  logic [N_W+SIZE_W-1:0]          scaled [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= point.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_comb begin
    scaled[0] = mag5[0] * scr_w;
    scaled[1] = mag5[1] * scr_h;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod1[r][c] <= m[r][c] * pt[c];
        end
        sum2[r]  <= SUM_W'(prod1[r][0]) + SUM_W'(prod1[r][1]) + SUM_W'(prod1[r][2]);
        clip3[r] <= CLIP_W'(sum2[r] >>> FRACTION_BITS) + CLIP_W'(m[r][3]);
      end

      vis4  <= clip3[ROW_W] >= $signed(CLIP_W'(THRESH));
      n4[0] <= N_W'(clip3[ROW_W]) + N_W'(clip3[ROW_X]);
      n4[1] <= N_W'(clip3[ROW_W]) - N_W'(clip3[ROW_Y]);
      d4    <= {clip3[ROW_W][CLIP_W-2:0], 1'b0};

      vis5 <= vis4;
      d5   <= d4;
      for (int l = 0; l < LANES; l++) begin
        neg5[l] <= n4[l][N_W-1];
        mag5[l] <= n4[l][N_W-1] ? N_W'(-n4[l]) : N_W'(n4[l]);
      end

      tag6.vis <= vis5;
      tag6.neg <= neg5;
      d6       <= d5;
      for (int l = 0; l < LANES; l++) begin
        num6[l] <= {scaled[l], {FRACTION_BITS{1'b0}}};
      end
    end
  end

  // stages 7 to 39: divider, a load stage then the quotient bits
  logic                      vq;
  logic [LANES-1:0][Q_W-1:0] quo;
  logic [LANES-1:0]          rem_nz;
  logic [LANES-1:0]          ovf;
  pps_tag_t                  tagq;

  pps_div #(
    .DW (CLIP_W),
    .NW (NUM_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v6),
    .num       (num6),
    .den       (d6),
    .in_tag    (tag6),
    .out_valid (vq),
    .quo       (quo),
    .rem_nz    (rem_nz),
    .ovf       (ovf),
    .out_tag   (tagq)
  );

  // floor for negative numerators is the rounded-up magnitude, negated
  logic [Q_W:0]          rnd [LANES];
  logic [LANES-1:0]      sat;
  logic signed [Q_W-1:0] val [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rnd[l] = {1'b0, quo[l]} + (Q_W+1)'(rem_nz[l]);
      if (tagq.neg[l]) begin
        sat[l] = ovf[l] || (rnd[l] > {2'b01, {(Q_W-1){1'b0}}});
        val[l] = sat[l] ? {1'b1, {(Q_W-1){1'b0}}} : -rnd[l][Q_W-1:0];
      end else begin
        sat[l] = ovf[l] || quo[l][Q_W-1];
        val[l] = sat[l] ? {1'b0, {(Q_W-1){1'b1}}} : quo[l];
      end
    end
  end

  // stage 40: saturated result
  logic        fv;
  pps_result_t fres;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (adv) begin
      fv <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fres.visible    <= tagq.vis;
      fres.screen_x   <= tagq.vis ? val[0] : '0;
      fres.screen_y   <= tagq.vis ? val[1] : '0;
      fres.overflowed <= tagq.vis && (|sat);
    end
  end

  // output register with one skid entry
  logic        out_vld;
  pps_result_t out_res;
  pps_result_t skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      priority if (skid_vld) begin
        if (screen.ready) begin
          out_res  <= skid_res;
          skid_vld <= 1'b0;
        end
      end else if (fv) begin
        if (!out_vld || screen.ready) begin
          out_res <= fres;
          out_vld <= 1'b1;
        end else begin
          skid_res <= fres;
          skid_vld <= 1'b1;
        end
      end else if (screen.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign screen.valid      = out_vld;
  assign screen.visible    = out_res.visible;
  assign screen.screen_x   = out_res.screen_x;
  assign screen.screen_y   = out_res.screen_y;
  assign screen.overflowed = out_res.overflowed;

endmodule
